@@ rtl/sso_pkg.sv @@
// shared constants, types and command/status structs for the span occlusion unit
`default_nettype none
package sso_pkg;

    localparam int LINES          = 512;
    localparam int SPANS_PER_LINE = 16;
    localparam int X_WIDTH        = 2048;

    localparam int LINE_W     = 9;
    localparam int COL_W      = 11;
    localparam int LADDR_W    = $clog2(LINES);
    localparam int SLOT_W     = $clog2(SPANS_PER_LINE);
    localparam int CNT_W      = $clog2(SPANS_PER_LINE + 1);
    localparam int PC_W       = $clog2(SPANS_PER_LINE + 2);
    localparam int SPAN_DW    = 2 * COL_W;
    localparam int SPAN_DEPTH = 2 * LINES * SPANS_PER_LINE;
    localparam int SPAN_AW    = $clog2(SPAN_DEPTH);
    localparam int LCNT_DW    = CNT_W + 1;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_COUNT,
        ST_ACK,
        ST_SLOT,
        ST_TAIL,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic init_wr;
        logic load;
        logic start;
        logic piece;
        logic adv;
        logic tail;
        logic flush;
        logic ack;
    } cmd_t;

    typedef struct packed {
        logic init_last;
        logic trivial;
        logic at_end;
        logic done;
        logic slot_piece;
        logic keep;
        logic cp;
        logic push_ok;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

@@ rtl/sso_ram.sv @@
// generic simple dual-port ram with registered read
`default_nettype none
module sso_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

@@ rtl/sso_ctrl.sv @@
// controller state machine sequencing the line walk
`default_nettype none
module sso_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire sso_pkg::status_t stat,
    output sso_pkg::cmd_t         cmd
);

    sso_pkg::state_t state_reg;
    sso_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sso_pkg::ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            sso_pkg::ST_INIT: begin
                cmd.init_wr = 1'b1;
                if (stat.init_last) begin
                    state_next = sso_pkg::ST_IDLE;
                end
            end
            sso_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = sso_pkg::ST_COUNT;
                end
            end
            sso_pkg::ST_COUNT: begin
                if (stat.trivial) begin
                    state_next = sso_pkg::ST_ACK;
                end else begin
                    cmd.start  = 1'b1;
                    state_next = sso_pkg::ST_SLOT;
                end
            end
            sso_pkg::ST_ACK: begin
                if (stat.out_free) begin
                    cmd.ack    = 1'b1;
                    state_next = sso_pkg::ST_IDLE;
                end
            end
            sso_pkg::ST_SLOT: begin
                if (stat.at_end) begin
                    state_next = sso_pkg::ST_TAIL;
                end else if (stat.slot_piece) begin
                    if (stat.push_ok) begin
                        cmd.piece = 1'b1;
                        cmd.adv   = !stat.keep;
                    end
                end else if (stat.done && !stat.cp) begin
                    state_next = sso_pkg::ST_TAIL;
                end else begin
                    cmd.adv = 1'b1;
                end
            end
            sso_pkg::ST_TAIL: begin
                if (stat.done) begin
                    state_next = sso_pkg::ST_FLUSH;
                end else if (stat.push_ok) begin
                    cmd.tail   = 1'b1;
                    state_next = sso_pkg::ST_FLUSH;
                end
            end
            sso_pkg::ST_FLUSH: begin
                if (stat.push_ok) begin
                    cmd.flush  = 1'b1;
                    state_next = sso_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sso_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/sso_dp.sv @@
// datapath: item registers, span and count memories, pending piece and result register
`default_nettype none
module sso_dp (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire sso_pkg::cmd_t               cmd,
    output sso_pkg::status_t                 stat,
    input  wire logic                        s_action,
    input  wire logic [sso_pkg::LINE_W-1:0]  s_line,
    input  wire logic [sso_pkg::COL_W-1:0]   s_start_x,
    input  wire logic [sso_pkg::COL_W-1:0]   s_end_x,
    input  wire logic                        s_transparent,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic      [sso_pkg::LINE_W-1:0]  m_out_line,
    output logic      [sso_pkg::COL_W-1:0]   m_piece_start,
    output logic      [sso_pkg::COL_W-1:0]   m_piece_end,
    output logic                             m_visible,
    output logic                             m_overflow,
    output logic                             m_last
);

    localparam int CW = sso_pkg::COL_W;
    localparam int LW = sso_pkg::LADDR_W;

    logic [LW-1:0]                  init_cnt_reg;
    logic                           act_reg;
    logic [sso_pkg::LINE_W-1:0]     line_reg;
    logic [CW-1:0]                  sx_reg;
    logic [CW-1:0]                  ex_reg;
    logic                           tr_reg;
    logic [sso_pkg::CNT_W-1:0]      n_reg;
    logic                           bank_reg;
    logic [sso_pkg::CNT_W-1:0]      i_reg;
    logic                           done_reg;
    logic                           cp_reg;
    logic [sso_pkg::PC_W-1:0]       pcnt_reg;
    logic [sso_pkg::CNT_W-1:0]      wr_idx_reg;
    logic                           pend_valid_reg;
    logic [CW-1:0]                  pend_s_reg;
    logic [CW-1:0]                  pend_e_reg;
    logic                           pend_ovf_reg;
    logic                           m_valid_reg;
    logic [sso_pkg::LINE_W-1:0]     m_line_reg;
    logic [CW-1:0]                  m_s_reg;
    logic [CW-1:0]                  m_e_reg;
    logic                           m_vis_reg;
    logic                           m_ovf_reg;
    logic                           m_last_reg;

    logic [sso_pkg::SPAN_DW-1:0]    span_rd;
    logic [sso_pkg::LCNT_DW-1:0]    cnt_rd;
    logic [CW-1:0]                  ssx;
    logic [CW-1:0]                  sex;
    logic [CW-1:0]                  sx_sat;
    logic [CW-1:0]                  ex_sat;
    logic [CW-1:0]                  piece_e;
    logic                           oor;
    logic                           keep;
    logic                           out_free;
    logic                           slot_piece;
    logic                           push;
    logic                           step;
    logic [sso_pkg::CNT_W-1:0]      i_plus;
    logic                           span_we;
    logic [sso_pkg::SPAN_AW-1:0]    span_wa;
    logic [sso_pkg::SPAN_DW-1:0]    span_wd;
    logic                           span_re;
    logic [sso_pkg::SPAN_AW-1:0]    span_ra;
    logic                           cnt_we;
    logic [LW-1:0]                  cnt_wa;
    logic [sso_pkg::LCNT_DW-1:0]    cnt_wd;

    assign ssx      = span_rd[CW-1:0];
    assign sex      = span_rd[sso_pkg::SPAN_DW-1:CW];
    assign sx_sat   = (32'(s_start_x) > sso_pkg::X_WIDTH) ? CW'(sso_pkg::X_WIDTH) : s_start_x;
    assign ex_sat   = (32'(s_end_x) > sso_pkg::X_WIDTH) ? CW'(sso_pkg::X_WIDTH) : s_end_x;
    assign oor      = 32'(line_reg) >= sso_pkg::LINES;
    assign out_free = !m_valid_reg || m_ready;
    assign slot_piece = !done_reg && (sx_reg < sex) && (sx_reg < ssx);
    assign keep     = cp_reg && (((sso_pkg::PC_W + 1)'(pcnt_reg) + (sso_pkg::PC_W + 1)'(n_reg))
                      < (sso_pkg::PC_W + 1)'(sso_pkg::SPANS_PER_LINE));
    assign piece_e  = cmd.tail ? ex_reg : ((ex_reg > ssx) ? ssx : ex_reg);
    assign push     = (cmd.piece || cmd.tail) && pend_valid_reg;
    assign step     = (cmd.piece || cmd.adv) && !done_reg && (sx_reg < sex);
    assign i_plus   = i_reg + 1'b1;

    always_comb begin
        stat            = '0;
        stat.init_last  = init_cnt_reg == LW'(sso_pkg::LINES - 1);
        stat.trivial    = (act_reg == sso_pkg::ACT_CLEAR) || oor || (ex_reg <= sx_reg);
        stat.at_end     = i_reg == n_reg;
        stat.done       = done_reg;
        stat.slot_piece = slot_piece;
        stat.keep       = keep;
        stat.cp         = cp_reg;
        stat.push_ok    = !pend_valid_reg || out_free;
        stat.out_free   = out_free;
    end

    // span memory: two banks per line, the walk copies into the other bank
    assign span_re = cmd.start || cmd.adv;
    assign span_ra = cmd.start
                   ? {cnt_rd[sso_pkg::CNT_W], line_reg[LW-1:0], sso_pkg::SLOT_W'(0)}
                   : {bank_reg, line_reg[LW-1:0], i_plus[sso_pkg::SLOT_W-1:0]};
    assign span_we = ((cmd.piece || cmd.tail) && keep) || (cmd.adv && cp_reg);
    assign span_wa = {~bank_reg, line_reg[LW-1:0], wr_idx_reg[sso_pkg::SLOT_W-1:0]};
    assign span_wd = ((cmd.piece || cmd.tail) && keep) ? {piece_e, sx_reg} : span_rd;

    assign cnt_we = cmd.init_wr || (cmd.ack && act_reg == sso_pkg::ACT_CLEAR && !oor)
                  || (cmd.flush && cp_reg);
    assign cnt_wa = cmd.init_wr ? init_cnt_reg : line_reg[LW-1:0];
    assign cnt_wd = cmd.flush ? {~bank_reg, wr_idx_reg} : '0;

    sso_ram #(
        .WIDTH (sso_pkg::SPAN_DW),
        .DEPTH (sso_pkg::SPAN_DEPTH)
    ) u_span_ram (
        .aclk    (aclk),
        .wr_en   (span_we),
        .wr_addr (span_wa),
        .wr_data (span_wd),
        .rd_en   (span_re),
        .rd_addr (span_ra),
        .rd_data (span_rd)
    );

    sso_ram #(
        .WIDTH (sso_pkg::LCNT_DW),
        .DEPTH (sso_pkg::LINES)
    ) u_count_ram (
        .aclk    (aclk),
        .wr_en   (cnt_we),
        .wr_addr (cnt_wa),
        .wr_data (cnt_wd),
        .rd_en   (cmd.load),
        .rd_addr (s_line[LW-1:0]),
        .rd_data (cnt_rd)
    );

    // item payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg  <= s_action;
            line_reg <= s_line;
            sx_reg   <= sx_sat;
            ex_reg   <= ex_sat;
            tr_reg   <= s_transparent;
        end else if (step && !((sx_reg < ssx && ex_reg <= ssx) || ex_reg <= sex)) begin
            sx_reg <= sex;
        end
        if (cmd.piece || cmd.tail) begin
            pend_s_reg   <= sx_reg;
            pend_e_reg   <= piece_e;
            pend_ovf_reg <= !tr_reg && !keep;
        end
    end

    // walk control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_cnt_reg   <= '0;
            n_reg          <= '0;
            bank_reg       <= 1'b0;
            i_reg          <= '0;
            done_reg       <= 1'b0;
            cp_reg         <= 1'b0;
            pcnt_reg       <= '0;
            wr_idx_reg     <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            if (cmd.init_wr) begin
                init_cnt_reg <= init_cnt_reg + 1'b1;
            end
            if (cmd.load) begin
                i_reg          <= '0;
                done_reg       <= 1'b0;
                pcnt_reg       <= '0;
                wr_idx_reg     <= '0;
                pend_valid_reg <= 1'b0;
            end else begin
                if (cmd.start) begin
                    n_reg    <= cnt_rd[sso_pkg::CNT_W-1:0];
                    bank_reg <= cnt_rd[sso_pkg::CNT_W];
                    cp_reg   <= !tr_reg && (32'(cnt_rd[sso_pkg::CNT_W-1:0])
                                < sso_pkg::SPANS_PER_LINE);
                end
                if (cmd.adv) begin
                    i_reg <= i_plus;
                end
                if (cmd.tail) begin
                    done_reg <= 1'b1;
                end else if (step && ((sx_reg < ssx && ex_reg <= ssx) || ex_reg <= sex)) begin
                    done_reg <= 1'b1;
                end
                if (cmd.piece || cmd.tail) begin
                    pcnt_reg       <= pcnt_reg + 1'b1;
                    pend_valid_reg <= 1'b1;
                end else if (cmd.flush) begin
                    pend_valid_reg <= 1'b0;
                end
                if (span_we) begin
                    wr_idx_reg <= wr_idx_reg + 1'b1;
                end
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (push || (cmd.flush && pend_valid_reg) || cmd.ack) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push || (cmd.flush && pend_valid_reg)) begin
            m_line_reg <= line_reg;
            m_s_reg    <= pend_s_reg;
            m_e_reg    <= pend_e_reg;
            m_vis_reg  <= 1'b1;
            m_ovf_reg  <= pend_ovf_reg;
            m_last_reg <= cmd.flush;
        end else if (cmd.ack) begin
            m_line_reg <= line_reg;
            m_s_reg    <= '0;
            m_e_reg    <= '0;
            m_vis_reg  <= 1'b0;
            m_ovf_reg  <= 1'b0;
            m_last_reg <= 1'b1;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_line    = m_line_reg;
    assign m_piece_start = m_s_reg;
    assign m_piece_end   = m_e_reg;
    assign m_visible     = m_vis_reg;
    assign m_overflow    = m_ovf_reg;
    assign m_last        = m_last_reg;

    a_wr_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(wr_idx_reg) <= sso_pkg::SPANS_PER_LINE)
        else $error("span write index beyond line capacity");

    a_pcnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(pcnt_reg) <= sso_pkg::SPANS_PER_LINE + 1)
        else $error("too many pieces for one item");

    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (push || (cmd.flush && pend_valid_reg) || cmd.ack) |-> out_free)
        else $error("result register overwritten while stalled");

    a_slot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.adv |-> (i_reg < n_reg))
        else $error("walk advanced past stored spans");

endmodule
`default_nettype wire

@@ rtl/scanline_span_occlusion_unit.sv @@
// top level of the scanline span occlusion unit
//
// input channel s_*: one item is an insert (span [start_x,end_x) on a line, solid or
// transparent) or a clear of one line. result channel m_*: each insert gives its
// uncovered pieces in ascending order, the final one marked with last; a fully covered
// span gives no result. an empty span or a clear gives one result with visible low.
// solid pieces are merged into the line's sorted list; once the line holds its capacity
// further pieces are still reported but flagged overflow and not stored.
// one item at a time: an insert walks the spans stored on the line through the simple
// dual-port span memory (one read and one write per cycle while no result stalls it);
// a piece stored in front of a stored span holds the walk on that slot, and a clear or
// empty span skips the walk.
// after reset the line count memory is swept to zero, line by line, during which
// s_ready stays low. a stalled receiver holds the result register and the walk waits
// whenever a new piece needs it; s_ready returns only when the walk is finished.
`default_nettype none
module scanline_span_occlusion_unit (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_action,
    input  wire logic [sso_pkg::LINE_W-1:0]  s_line,
    input  wire logic [sso_pkg::COL_W-1:0]   s_start_x,
    input  wire logic [sso_pkg::COL_W-1:0]   s_end_x,
    input  wire logic                        s_transparent,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic      [sso_pkg::LINE_W-1:0]  m_out_line,
    output logic      [sso_pkg::COL_W-1:0]   m_piece_start,
    output logic      [sso_pkg::COL_W-1:0]   m_piece_end,
    output logic                             m_visible,
    output logic                             m_overflow,
    output logic                             m_last
);

    sso_pkg::cmd_t    cmd;
    sso_pkg::status_t stat;

    sso_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    sso_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_action      (s_action),
        .s_line        (s_line),
        .s_start_x     (s_start_x),
        .s_end_x       (s_end_x),
        .s_transparent (s_transparent),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_line    (m_out_line),
        .m_piece_start (m_piece_start),
        .m_piece_end   (m_piece_end),
        .m_visible     (m_visible),
        .m_overflow    (m_overflow),
        .m_last        (m_last)
    );

endmodule
`default_nettype wire

@@ sim/tb_scanline_span_occlusion_unit.sv @@
// self-checking testbench for the scanline span occlusion unit
`default_nettype none
module tb_scanline_span_occlusion_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1500000;

    typedef struct {
        logic [sso_pkg::LINE_W-1:0] ln;
        logic [sso_pkg::COL_W-1:0]  ps;
        logic [sso_pkg::COL_W-1:0]  pe;
        logic                       vis;
        logic                       ovf;
        logic                       lst;
    } piece_t;

    class span_scoreboard;
        int unsigned cov_s[sso_pkg::LINES][sso_pkg::SPANS_PER_LINE];
        int unsigned cov_e[sso_pkg::LINES][sso_pkg::SPANS_PER_LINE];
        int unsigned cov_n[sso_pkg::LINES];
        piece_t      pieces_due[$];
        int          mismatches;

        function new();
            foreach (cov_n[i]) cov_n[i] = 0;
            mismatches = 0;
        endfunction

        function void note_item(logic act, logic [sso_pkg::LINE_W-1:0] ln,
                                logic [sso_pkg::COL_W-1:0] sx_in,
                                logic [sso_pkg::COL_W-1:0] ex_in, logic tr);
            int unsigned sx, ex, n, np, room, keep, a, b, m;
            int unsigned ps[sso_pkg::SPANS_PER_LINE+1];
            int unsigned pe[sso_pkg::SPANS_PER_LINE+1];
            int unsigned ms[sso_pkg::SPANS_PER_LINE];
            int unsigned me[sso_pkg::SPANS_PER_LINE];
            bit done;
            piece_t p;
            sx = sx_in;
            ex = ex_in;
            np = 0;
            room = 0;
            done = 0;
            p.ln = ln; p.ps = '0; p.pe = '0; p.vis = 0; p.ovf = 0; p.lst = 1;
            if (act == sso_pkg::ACT_CLEAR) begin
                cov_n[ln] = 0;
                pieces_due.push_back(p);
                return;
            end
            if (sx > sso_pkg::X_WIDTH) sx = sso_pkg::X_WIDTH;
            if (ex > sso_pkg::X_WIDTH) ex = sso_pkg::X_WIDTH;
            if (ex <= sx) begin
                pieces_due.push_back(p);
                return;
            end
            n = cov_n[ln];
            for (int i = 0; i < n; i++) begin
                if (sx < cov_e[ln][i]) begin
                    if (sx < cov_s[ln][i]) begin
                        ps[np] = sx;
                        pe[np] = (ex > cov_s[ln][i]) ? cov_s[ln][i] : ex;
                        np++;
                        if (ex <= cov_s[ln][i]) begin
                            done = 1;
                            break;
                        end
                    end
                    if (ex <= cov_e[ln][i]) begin
                        done = 1;
                        break;
                    end
                    sx = cov_e[ln][i];
                end
            end
            if (!done) begin
                ps[np] = sx;
                pe[np] = ex;
                np++;
            end
            if (!tr) begin
                room = sso_pkg::SPANS_PER_LINE - n;
                keep = (np < room) ? np : room;
                a = 0; b = 0; m = 0;
                while (a < n || b < keep) begin
                    if (b >= keep || (a < n && cov_s[ln][a] < ps[b])) begin
                        ms[m] = cov_s[ln][a]; me[m] = cov_e[ln][a]; a++;
                    end else begin
                        ms[m] = ps[b]; me[m] = pe[b]; b++;
                    end
                    m++;
                end
                for (int i = 0; i < m; i++) begin
                    cov_s[ln][i] = ms[i];
                    cov_e[ln][i] = me[i];
                end
                cov_n[ln] = m;
            end
            for (int i = 0; i < np; i++) begin
                p.ps  = ps[i];
                p.pe  = pe[i];
                p.vis = 1;
                p.ovf = (!tr && i >= room);
                p.lst = (i + 1 == np);
                pieces_due.push_back(p);
            end
        endfunction

        function void check_piece(piece_t got);
            piece_t want;
            if (pieces_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected piece line %0d [%0d,%0d) vis %0b ovf %0b last %0b",
                             got.ln, got.ps, got.pe, got.vis, got.ovf, got.lst);
                return;
            end
            want = pieces_due.pop_front();
            if (got.ln !== want.ln || got.ps !== want.ps || got.pe !== want.pe ||
                got.vis !== want.vis || got.ovf !== want.ovf || got.lst !== want.lst) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"piece mismatch: want %0d [%0d,%0d) %0b%0b%0b",
                              " got %0d [%0d,%0d) %0b%0b%0b"},
                             want.ln, want.ps, want.pe, want.vis, want.ovf, want.lst,
                             got.ln, got.ps, got.pe, got.vis, got.ovf, got.lst);
            end
        endfunction
    endclass

    logic                       aclk = 0;
    logic                       aresetn = 0;
    logic                       s_valid = 0;
    logic                       s_ready;
    logic                       s_action = sso_pkg::ACT_INSERT;
    logic [sso_pkg::LINE_W-1:0] s_line = '0;
    logic [sso_pkg::COL_W-1:0]  s_start_x = '0;
    logic [sso_pkg::COL_W-1:0]  s_end_x = '0;
    logic                       s_transparent = 0;
    logic                       m_valid;
    logic                       m_ready = 0;
    logic [sso_pkg::LINE_W-1:0] m_out_line;
    logic [sso_pkg::COL_W-1:0]  m_piece_start;
    logic [sso_pkg::COL_W-1:0]  m_piece_end;
    logic                       m_visible;
    logic                       m_overflow;
    logic                       m_last;

    span_scoreboard sb = new();
    int             cycles = 0;
    bit             sending = 1;

    scanline_span_occlusion_unit dut (.*);

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge aclk) begin
        piece_t got;
        if (aresetn && m_valid && m_ready) begin
            got.ln = m_out_line; got.ps = m_piece_start; got.pe = m_piece_end;
            got.vis = m_visible; got.ovf = m_overflow; got.lst = m_last;
            sb.check_piece(got);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side stall
    initial begin
        int hold;
        forever begin
            @(negedge aclk);
            if (!sending) begin
                m_ready = 1;
            end else if (hold > 0) begin
                hold--;
            end else begin
                hold = pick_gap();
                m_ready = (hold == 0);
            end
        end
    end

    task automatic send_item(logic act, int ln, int sx, int ex, logic tr);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid = 0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid = 1;
        s_action = act;
        s_line = ln;
        s_start_x = sx;
        s_end_x = ex;
        s_transparent = tr;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(act, s_line, s_start_x, s_end_x, tr);
    endtask

    initial begin
        int ln, sx, ex, r;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // directed
        send_item(sso_pkg::ACT_CLEAR, 0, 0, 0, 0);
        send_item(sso_pkg::ACT_INSERT, 0, 0, 2047, 0);
        send_item(sso_pkg::ACT_INSERT, 0, 100, 200, 0);
        send_item(sso_pkg::ACT_INSERT, 0, 5, 5, 0);
        send_item(sso_pkg::ACT_INSERT, 0, 2047, 3, 0);
        send_item(sso_pkg::ACT_INSERT, 0, 2046, 2047, 1);
        send_item(sso_pkg::ACT_CLEAR, 0, 2047, 2047, 1);
        send_item(sso_pkg::ACT_INSERT, 511, 2046, 2047, 0);
        send_item(sso_pkg::ACT_INSERT, 511, 0, 2047, 1);
        send_item(sso_pkg::ACT_INSERT, 511, 0, 2047, 0);
        for (int i = 0; i < 17; i++)
            send_item(sso_pkg::ACT_INSERT, 1, i * 10 + 3, i * 10 + 8, 0);
        send_item(sso_pkg::ACT_INSERT, 1, 0, 2047, 1);
        send_item(sso_pkg::ACT_INSERT, 1, 0, 2047, 0);
        send_item(sso_pkg::ACT_CLEAR, 1, 0, 0, 0);

        // random
        for (int k = 0; k < 380; k++) begin
            r = $urandom_range(0, 99);
            ln = (r < 85) ? $urandom_range(0, 7) : $urandom_range(0, 511);
            r = $urandom_range(0, 99);
            if (r < 10) begin
                sx = $urandom_range(0, 2047);
                ex = $urandom_range(0, 2047);
            end else begin
                sx = $urandom_range(0, 2047);
                ex = sx + $urandom_range(1, 200);
                if (ex > 2047) ex = 2047;
            end
            send_item(($urandom_range(0, 99) < 6) ? sso_pkg::ACT_CLEAR : sso_pkg::ACT_INSERT,
                      ln, sx, ex, $urandom_range(0, 99) < 25);
        end
        @(negedge aclk);
        s_valid = 0;
        sending = 0;

        while (sb.pieces_due.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
`default_nettype wire
